/* sv/tbls_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbls_pkg
// shared types, constants and helpers for the terrain block level-of-detail
// selector
// ----------------------------------------------------------------------------
package tbls_pkg;

   localparam int MaxLevels = 8;
   localparam int ErrW      = 13;
   localparam int DistW     = 50;
   localparam int ThrW      = 40;
   localparam int ProdW     = 58;
   localparam int BlendW    = 17;
   localparam int QuoW      = 16;
   localparam int DivSteps  = 16;
   localparam int StepW     = 4;
   localparam int LevelW    = 3;
   localparam int LvW       = 4;

   localparam logic [ErrW-1:0] ErrClamp = 13'd6554;

   // configuration register indexes
   localparam logic [2:0] CsrCenterX   = 3'd0;
   localparam logic [2:0] CsrCenterY   = 3'd1;
   localparam logic [2:0] CsrCenterZ   = 3'd2;
   localparam logic [2:0] CsrQuality   = 3'd3;
   localparam logic [2:0] CsrNumLevels = 3'd4;

   localparam logic OpSample = 1'b0;
   localparam logic OpQuery  = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE, ST_MUL_DX, ST_MUL_DY, ST_MUL_DZ, ST_MUL_ESQ, ST_MUL_QSQ,
      ST_MUL_PROD, ST_LEVEL, ST_PREP, ST_DIV, ST_DONE
   } state_type;

   typedef enum logic [2:0] {
      MUL_NONE, MUL_DX, MUL_DY, MUL_DZ, MUL_ERR, MUL_QUAL, MUL_PROD
   } mul_sel_type;

   typedef struct packed {
      logic        accept;
      mul_sel_type mul_sel;
      logic        acc_load;
      logic        acc_add;
      logic        esq_load;
      logic        level_load;
      logic        prep;
      logic        div_step;
      logic        div_last;
   } ctl_type;

   typedef struct packed {
      logic need_div;
   } stat_type;

   // scaled threshold floor((p << 2(i-1)) / 2^32), zero for level 0
   function automatic logic [ThrW-1:0] scaled_thr(logic [ProdW-1:0] p,
                                                  logic [LevelW-1:0] i);
      logic [71:0]       wide;
      logic [LevelW-1:0] im1;
      im1  = i - 3'd1;
      wide = {14'd0, p} << {im1, 1'b0};
      if (i == '0) begin
         return '0;
      end
      return wide[71:32];
   endfunction

endpackage

/* sv/tbls_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbls_ctrl
// sequencer for the shared multiplier, level pick and serial divider
// ----------------------------------------------------------------------------
module tbls_ctrl import tbls_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   input  logic     req_opcode,
   input  logic     req_last,
   input  logic     out_free,
   input  stat_type stat,
   output ctl_type  ctl,
   output logic     req_stall,
   output logic     done,
   output logic     done_kind
);

   state_type        state_ff, state_in;
   logic [StepW-1:0] step_ff, step_in;
   logic             kind_ff, kind_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
         kind_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         kind_ff  <= kind_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      kind_in   = kind_ff;
      ctl       = '0;
      ctl.mul_sel = MUL_NONE;
      req_stall = (state_ff != ST_IDLE);
      done      = 1'b0;
      done_kind = kind_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               ctl.accept = 1'b1;
               kind_in    = req_opcode;
               if (req_opcode == OpQuery) begin
                  state_in = ST_MUL_DX;
               end else if (req_last) begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_MUL_DX: begin
            ctl.mul_sel = MUL_DX;
            state_in    = ST_MUL_DY;
         end
         ST_MUL_DY: begin
            ctl.mul_sel  = MUL_DY;
            ctl.acc_load = 1'b1;
            state_in     = ST_MUL_DZ;
         end
         ST_MUL_DZ: begin
            ctl.mul_sel = MUL_DZ;
            ctl.acc_add = 1'b1;
            state_in    = ST_MUL_ESQ;
         end
         ST_MUL_ESQ: begin
            ctl.mul_sel = MUL_ERR;
            ctl.acc_add = 1'b1;
            state_in    = ST_MUL_QSQ;
         end
         ST_MUL_QSQ: begin
            ctl.mul_sel  = MUL_QUAL;
            ctl.esq_load = 1'b1;
            state_in     = ST_MUL_PROD;
         end
         ST_MUL_PROD: begin
            ctl.mul_sel = MUL_PROD;
            state_in    = ST_LEVEL;
         end
         ST_LEVEL: begin
            ctl.level_load = 1'b1;
            state_in       = ST_PREP;
         end
         ST_PREP: begin
            ctl.prep = 1'b1;
            step_in  = '0;
            state_in = stat.need_div ? ST_DIV : ST_DONE;
         end
         ST_DIV: begin
            ctl.div_step = 1'b1;
            ctl.div_last = (step_ff == StepW'(DivSteps - 1));
            step_in      = step_ff + 1'b1;
            if (ctl.div_last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               done     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

/* sv/tbls_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbls_dp
// registers, error tracking, shared multiplier, level pick and divider
// ----------------------------------------------------------------------------
module tbls_dp import tbls_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  ctl_type                 ctl,
   output stat_type                stat,
   input  logic                    csr_we,
   input  logic [2:0]              csr_index,
   input  logic [23:0]             csr_wdata,
   input  logic                    req_opcode,
   input  logic signed [31:0]      req_center_height,
   input  logic signed [31:0]      req_neighbor_a_height,
   input  logic signed [31:0]      req_neighbor_b_height,
   input  logic                    req_first,
   input  logic                    req_last,
   input  logic signed [23:0]      req_cam_x,
   input  logic signed [23:0]      req_cam_y,
   input  logic signed [23:0]      req_cam_z,
   output logic [ErrW-1:0]         running_error,
   output logic                    below_flag,
   output logic                    above_flag,
   output logic [LevelW-1:0]       level,
   output logic [BlendW-1:0]       blend
);

   logic signed [23:0] cx_ff, cy_ff, cz_ff;
   logic [15:0]        qual_ff;
   logic [LvW-1:0]     nlev_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cx_ff   <= '0;
         cy_ff   <= '0;
         cz_ff   <= '0;
         qual_ff <= 16'd256;
         nlev_ff <= LvW'(MaxLevels);
      end else if (csr_we) begin
         priority case (csr_index)
            CsrCenterX:   cx_ff   <= csr_wdata;
            CsrCenterY:   cy_ff   <= csr_wdata;
            CsrCenterZ:   cz_ff   <= csr_wdata;
            CsrQuality:   qual_ff <= csr_wdata[15:0];
            CsrNumLevels: nlev_ff <= csr_wdata[LvW-1:0];
            default: ;
         endcase
      end
   end

   // midpoint error of the sample
   logic signed [33:0] e2;
   logic [33:0]        e2_abs;
   logic [32:0]        err_full;
   logic [ErrW-1:0]    err_cl, run_base, run_in;
   logic               below_in, above_in;

   always_comb begin
      e2       = (34'(req_center_height) <<< 1) - 34'(req_neighbor_a_height)
                 - 34'(req_neighbor_b_height);
      e2_abs   = e2[33] ? 34'(-e2) : 34'(e2);
      err_full = e2_abs[33:1];
      err_cl   = (err_full > 33'(ErrClamp)) ? ErrClamp : err_full[ErrW-1:0];
      run_base = req_first ? '0 : running_error;
      run_in   = (err_cl > run_base) ? err_cl : run_base;
      below_in = (req_first ? 1'b0 : below_flag) | (req_center_height < 0);
      above_in = (req_first ? 1'b0 : above_flag) | (req_center_height > 0);
   end

   logic [24:0]     adx_ff, ady_ff, adz_ff;

   function automatic logic [24:0] abs_diff(logic signed [23:0] a,
                                            logic signed [23:0] b);
      logic signed [24:0] d;
      d = 25'(a) - 25'(b);
      return d[24] ? 25'(-d) : 25'(d);
   endfunction

   always_ff @(posedge clock) begin
      if (ctl.accept) begin
         adx_ff <= abs_diff(req_cam_x, cx_ff);
         ady_ff <= abs_diff(req_cam_y, cy_ff);
         adz_ff <= abs_diff(req_cam_z, cz_ff);
      end
   end

   // sample state, updated only by samples
   logic [ErrW-1:0] run_s_ff, tbl_s_ff;
   logic            below_s_ff, above_s_ff;

   assign running_error = run_s_ff;
   assign below_flag    = below_s_ff;
   assign above_flag    = above_s_ff;

   logic req_is_sample;
   logic sample_go;
   assign req_is_sample = (req_opcode == OpSample);
   assign sample_go = ctl.accept && (ctl.mul_sel == MUL_NONE) && req_is_sample;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_s_ff   <= '0;
         below_s_ff <= 1'b0;
         above_s_ff <= 1'b0;
         tbl_s_ff   <= '0;
      end else if (sample_go) begin
         run_s_ff   <= run_in;
         below_s_ff <= below_in;
         above_s_ff <= above_in;
         if (req_last) begin
            tbl_s_ff <= run_in;
         end else if (req_first) begin
            tbl_s_ff <= '0;
         end
      end
   end

   // shared multiplier
   logic [31:0] mul_a, mul_b;
   logic [63:0] mul_ff;
   logic [25:0] esq_ff;
   logic [DistW-1:0] acc_ff;

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (ctl.mul_sel)
         MUL_NONE: ;
         MUL_DX:   begin mul_a = 32'(adx_ff); mul_b = 32'(adx_ff); end
         MUL_DY:   begin mul_a = 32'(ady_ff); mul_b = 32'(ady_ff); end
         MUL_DZ:   begin mul_a = 32'(adz_ff); mul_b = 32'(adz_ff); end
         MUL_ERR:  begin mul_a = 32'(tbl_s_ff); mul_b = 32'(tbl_s_ff); end
         MUL_QUAL: begin mul_a = 32'(qual_ff); mul_b = 32'(qual_ff); end
         MUL_PROD: begin mul_a = 32'(esq_ff); mul_b = mul_ff[31:0]; end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (ctl.mul_sel != MUL_NONE) begin
         mul_ff <= mul_a * mul_b;
      end
      if (ctl.acc_load) begin
         acc_ff <= mul_ff[DistW-1:0];
      end else if (ctl.acc_add) begin
         acc_ff <= acc_ff + mul_ff[DistW-1:0];
      end
      if (ctl.esq_load) begin
         esq_ff <= mul_ff[25:0];
      end
   end

   // level pick
   logic [LvW-1:0]    lv;
   logic [LevelW-1:0] lvl_pick;
   logic              run_ok;
   logic [ProdW-1:0]  prod;

   assign prod = mul_ff[ProdW-1:0];

   always_comb begin
      if (nlev_ff == '0) begin
         lv = LvW'(1);
      end else if (nlev_ff > LvW'(MaxLevels)) begin
         lv = LvW'(MaxLevels);
      end else begin
         lv = nlev_ff;
      end
      lvl_pick = '0;
      run_ok   = 1'b1;
      for (int i = 1; i < MaxLevels; i++) begin
         if (run_ok && (LvW'(i) < lv) &&
             (acc_ff > DistW'(scaled_thr(prod, LevelW'(i))))) begin
            lvl_pick = LevelW'(i);
         end else begin
            run_ok = 1'b0;
         end
      end
   end

   logic [LevelW-1:0] level_ff;
   logic [BlendW-1:0] blend_ff;
   logic [ThrW-1:0]   den_ff;
   logic [ThrW-1:0]   rem_ff;
   logic [QuoW-1:0]   quo_ff;

   // blend set-up
   logic [ThrW-1:0]  d0, d1, den;
   logic [DistW-1:0] r_full;
   logic             need_blend, trivial_zero, trivial_full;

   always_comb begin
      d0           = scaled_thr(prod, level_ff);
      d1           = scaled_thr(prod, LevelW'(level_ff + 1'b1));
      den          = d1 - d0;
      r_full       = acc_ff - DistW'(d0);
      need_blend   = ({1'b0, level_ff} + 4'd1) < lv;
      trivial_zero = (d1 <= d0) || (acc_ff <= DistW'(d0));
      trivial_full = (r_full >= DistW'(den));
      stat.need_div = need_blend && !trivial_zero && !trivial_full;
   end

   // restoring divider step
   logic [ThrW:0]   rs;
   logic [ThrW-1:0] rem_in;
   logic [QuoW-1:0] quo_in;

   always_comb begin
      rs = {rem_ff, 1'b0};
      if (rs >= {1'b0, den_ff}) begin
         rem_in = ThrW'(rs - {1'b0, den_ff});
         quo_in = {quo_ff[QuoW-2:0], 1'b1};
      end else begin
         rem_in = rs[ThrW-1:0];
         quo_in = {quo_ff[QuoW-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= '0;
         blend_ff <= '0;
      end else begin
         if (ctl.level_load) begin
            level_ff <= lvl_pick;
         end
         if (ctl.prep && need_blend) begin
            if (trivial_zero) begin
               blend_ff <= '0;
            end else if (trivial_full) begin
               blend_ff <= BlendW'(1 << QuoW);
            end
         end
         if (ctl.div_step && ctl.div_last) begin
            blend_ff <= {1'b0, quo_in};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.prep) begin
         den_ff <= den;
         rem_ff <= r_full[ThrW-1:0];
         quo_ff <= '0;
      end else if (ctl.div_step) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign level = level_ff;
   assign blend = blend_ff;

endmodule

/* sv/terrain_block_lod_select.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// terrain_block_lod_select
// per-block height error summary and camera level-of-detail pick
// ----------------------------------------------------------------------------
// usage
//   req_ channel: one item per handshake (req_valid high, req_stall low).
//   opcode 0 is a height sample, opcode 1 a camera query.
//   samples without last give no result and leave the block idle.
//   a sample with last gives a summary item through the done state.
//   a query runs six passes of the shared 32x32 multiplier, a level pick
//   step, a set-up step and, when the blend needs a division, sixteen steps
//   of the restoring divider before its answer goes through the done state.
//   rsp_ channel: result items sit in an output register; the next request
//   is taken while a result still waits there.
//   if the receiver stalls, a finished result waits in the controller until
//   the output register frees up, and req_stall stays high meanwhile.
//   csr_ port: plain writes by index, by the user only while the block is idle, unchecked.
//   reset (synchronous) clears the running error, flags, threshold table,
//   level and blend, and loads the default centre, quality and level count.
// ----------------------------------------------------------------------------
module terrain_block_lod_select import tbls_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_we,
   input  logic [2:0]         csr_index,
   input  logic [23:0]        csr_wdata,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_opcode,
   input  logic signed [31:0] req_center_height,
   input  logic signed [31:0] req_neighbor_a_height,
   input  logic signed [31:0] req_neighbor_b_height,
   input  logic               req_first,
   input  logic               req_last,
   input  logic signed [23:0] req_cam_x,
   input  logic signed [23:0] req_cam_y,
   input  logic signed [23:0] req_cam_z,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_result_kind,
   output logic [12:0]        rsp_max_error,
   output logic               rsp_under_water,
   output logic               rsp_over_water,
   output logic [2:0]         rsp_detail_level,
   output logic [16:0]        rsp_blend
);

   ctl_type           ctl;
   stat_type          stat;
   logic              done, done_kind, out_free;
   logic [ErrW-1:0]   run_err;
   logic              below, above;
   logic [LevelW-1:0] level;
   logic [BlendW-1:0] blend;

   // output register is free when empty or being taken this cycle
   assign out_free = !rsp_valid || !rsp_stall;

   tbls_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_opcode (req_opcode),
      .req_last   (req_last),
      .out_free   (out_free),
      .stat       (stat),
      .ctl        (ctl),
      .req_stall  (req_stall),
      .done       (done),
      .done_kind  (done_kind)
   );

   tbls_dp u_dp (
      .clock                 (clock),
      .reset                 (reset),
      .ctl                   (ctl),
      .stat                  (stat),
      .csr_we                (csr_we),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata),
      .req_opcode            (req_opcode),
      .req_center_height     (req_center_height),
      .req_neighbor_a_height (req_neighbor_a_height),
      .req_neighbor_b_height (req_neighbor_b_height),
      .req_first             (req_first),
      .req_last              (req_last),
      .req_cam_x             (req_cam_x),
      .req_cam_y             (req_cam_y),
      .req_cam_z             (req_cam_z),
      .running_error         (run_err),
      .below_flag            (below),
      .above_flag            (above),
      .level                 (level),
      .blend                 (blend)
   );

   // result register
   logic              valid_ff;
   logic              kind_ff;
   logic [ErrW-1:0]   err_ff;
   logic              under_ff, over_ff;
   logic [LevelW-1:0] lvl_ff;
   logic [BlendW-1:0] blend_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (done) begin
         valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (done) begin
         kind_ff <= done_kind;
         if (done_kind == OpQuery) begin
            // level answer: summary fields read as zero
            err_ff   <= '0;
            under_ff <= 1'b0;
            over_ff  <= 1'b0;
            lvl_ff   <= level;
            blend_ff <= blend;
         end else begin
            // block summary: level fields read as zero
            err_ff   <= run_err;
            under_ff <= below;
            over_ff  <= above;
            lvl_ff   <= '0;
            blend_ff <= '0;
         end
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_result_kind  = kind_ff;
   assign rsp_max_error    = err_ff;
   assign rsp_under_water  = under_ff;
   assign rsp_over_water   = over_ff;
   assign rsp_detail_level = lvl_ff;
   assign rsp_blend        = blend_ff;

endmodule

/* verif/terrain_block_lod_select_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// terrain_block_lod_select_checker
// watches the request, result and register ports of the level-of-detail
// selector, predicts every result item and compares it field by field
// ----------------------------------------------------------------------------
module terrain_block_lod_select_checker import tbls_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_we,
   input  logic [2:0]         csr_index,
   input  logic [23:0]        csr_wdata,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic               req_opcode,
   input  logic signed [31:0] req_center_height,
   input  logic signed [31:0] req_neighbor_a_height,
   input  logic signed [31:0] req_neighbor_b_height,
   input  logic               req_first,
   input  logic               req_last,
   input  logic signed [23:0] req_cam_x,
   input  logic signed [23:0] req_cam_y,
   input  logic signed [23:0] req_cam_z,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic               rsp_result_kind,
   input  logic [12:0]        rsp_max_error,
   input  logic               rsp_under_water,
   input  logic               rsp_over_water,
   input  logic [2:0]         rsp_detail_level,
   input  logic [16:0]        rsp_blend,
   output int                 fail_count,
   output int                 pending
);

   typedef struct {
      logic        kind;
      logic [12:0] err;
      logic        under;
      logic        over;
      logic [2:0]  level;
      logic [16:0] blend;
   } lod_result_t;

   lod_result_t lod_expected[$];

   logic signed [23:0] ctr_x, ctr_y, ctr_z;
   logic [15:0]        qual;
   logic [3:0]         levels;
   logic [12:0]        err_max;
   logic               below, above;
   logic [63:0]        thr[MaxLevels];
   logic [2:0]         level_q;
   logic [16:0]        blend_q;

   // floor(t * q2 / 2^32) without losing bits
   function automatic logic [63:0] scale_thr(logic [63:0] t, logic [63:0] q2);
      logic [127:0] prod;
      prod = 128'(t) * 128'(q2);
      return prod[95:32];
   endfunction

   function automatic void predict_lod();
      lod_result_t r;
      longint c, a, b, e2, dx, dy, dz;
      logic [63:0] err, d2, q2, d0, d1, den, num;
      logic [127:0] quo;
      int lv, lvl;
      r = '{default: '0};
      if (req_opcode == OpSample) begin
         c  = longint'(req_center_height);
         a  = longint'(req_neighbor_a_height);
         b  = longint'(req_neighbor_b_height);
         e2 = 2 * c - a - b;
         err = ((e2 < 0) ? -e2 : e2) >> 1;
         if (err > 64'(ErrClamp)) err = 64'(ErrClamp);
         if (req_first) begin
            err_max = '0;
            below = 1'b0;
            above = 1'b0;
            for (int i = 0; i < MaxLevels; i++) thr[i] = '0;
         end
         if (err > 64'(err_max)) err_max = err[12:0];
         if (c < 0) below = 1'b1;
         if (c > 0) above = 1'b1;
         if (!req_last) return;
         thr[0] = '0;
         for (int i = 1; i < MaxLevels; i++) begin
            d0 = 64'(err_max) << (i - 1);
            thr[i] = d0 * d0;
         end
         r.err   = err_max;
         r.under = below;
         r.over  = above;
      end else begin
         dx = longint'(req_cam_x) - longint'(ctr_x);
         dy = longint'(req_cam_y) - longint'(ctr_y);
         dz = longint'(req_cam_z) - longint'(ctr_z);
         d2 = dx * dx + dy * dy + dz * dz;
         q2 = 64'(qual) * 64'(qual);
         lv = int'(levels);
         if (lv < 1) lv = 1;
         if (lv > MaxLevels) lv = MaxLevels;
         lvl = 0;
         for (int i = 1; i < lv; i++) begin
            if (!(d2 > scale_thr(thr[i], q2))) break;
            lvl = i;
         end
         // at the top level the blend is left as it was
         if (lvl + 1 < lv) begin
            d0 = scale_thr(thr[lvl], q2);
            d1 = scale_thr(thr[lvl + 1], q2);
            if (d1 <= d0 || d2 <= d0) begin
               blend_q = '0;
            end else begin
               den = d1 - d0;
               num = d2 - d0;
               if (num >= den) begin
                  blend_q = 17'd65536;
               end else begin
                  quo = (128'(num) << 16) / 128'(den);
                  blend_q = quo[16:0];
               end
            end
         end
         level_q = lvl[2:0];
         r.kind  = 1'b1;
         r.level = level_q;
         r.blend = blend_q;
      end
      lod_expected.push_back(r);
   endfunction

   always @(posedge clock) begin
      lod_result_t e;
      if (reset) begin
         ctr_x <= '0; ctr_y <= '0; ctr_z <= '0;
         qual <= 16'd256;
         levels <= 4'd8;
         err_max = '0;
         below = 1'b0;
         above = 1'b0;
         for (int i = 0; i < MaxLevels; i++) thr[i] = '0;
         level_q = '0;
         blend_q = '0;
         lod_expected.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CsrCenterX:   ctr_x <= csr_wdata;
               CsrCenterY:   ctr_y <= csr_wdata;
               CsrCenterZ:   ctr_z <= csr_wdata;
               CsrQuality:   qual <= csr_wdata[15:0];
               CsrNumLevels: levels <= csr_wdata[3:0];
               default: ;
            endcase
         end
         // results first, so an item taken this edge cannot cover a stray one
         if (rsp_valid && !rsp_stall) begin
            if (lod_expected.size() == 0) begin
               $error("result item with nothing expected");
               fail_count++;
            end else begin
               e = lod_expected.pop_front();
               if (rsp_result_kind !== e.kind) begin
                  $error("result_kind: expected %0d got %0d", e.kind, rsp_result_kind);
                  fail_count++;
               end
               if (rsp_max_error !== e.err) begin
                  $error("max_error: expected %0d got %0d", e.err, rsp_max_error);
                  fail_count++;
               end
               if (rsp_under_water !== e.under) begin
                  $error("under_water: expected %0d got %0d", e.under, rsp_under_water);
                  fail_count++;
               end
               if (rsp_over_water !== e.over) begin
                  $error("over_water: expected %0d got %0d", e.over, rsp_over_water);
                  fail_count++;
               end
               if (rsp_detail_level !== e.level) begin
                  $error("detail_level: expected %0d got %0d", e.level, rsp_detail_level);
                  fail_count++;
               end
               if (rsp_blend !== e.blend) begin
                  $error("blend: expected %0d got %0d", e.blend, rsp_blend);
                  fail_count++;
               end
            end
         end
         if (req_valid && !req_stall) predict_lod();
      end
      pending = lod_expected.size();
   end

   initial begin
      fail_count = 0;
      pending = 0;
   end

endmodule

/* verif/terrain_block_lod_select_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// terrain_block_lod_select_tb
// drives height samples and camera queries into the level-of-detail selector
// under random idling and a long receiver hold-off, and gives the verdict
// ----------------------------------------------------------------------------
module terrain_block_lod_select_tb;
   import tbls_pkg::*;

   localparam int CycleLimit = 400000;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               csr_we = 1'b0;
   logic [2:0]         csr_index = '0;
   logic [23:0]        csr_wdata = '0;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic               req_opcode = OpSample;
   logic signed [31:0] req_center_height = '0;
   logic signed [31:0] req_neighbor_a_height = '0;
   logic signed [31:0] req_neighbor_b_height = '0;
   logic               req_first = 1'b0;
   logic               req_last = 1'b0;
   logic signed [23:0] req_cam_x = '0;
   logic signed [23:0] req_cam_y = '0;
   logic signed [23:0] req_cam_z = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic               rsp_result_kind;
   logic [12:0]        rsp_max_error;
   logic               rsp_under_water;
   logic               rsp_over_water;
   logic [2:0]         rsp_detail_level;
   logic [16:0]        rsp_blend;

   int fail_count;
   int pending;
   int cycle_count = 0;
   int send_pct = 0;
   int recv_pct = 0;
   int hold_asks = 0;   // bumped by the stimulus to ask for a long hold-off
   int hold_seen = 0;
   int hold_left = 0;
   int items_sent = 0;

   // current configuration as the stimulus sees it, for aiming camera items
   int ctr_x = 0, ctr_y = 0, ctr_z = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   terrain_block_lod_select u_dut (.*);

   terrain_block_lod_select_checker u_checker (.*);

   // receiver: random stalls, plus a long hold when asked
   always @(negedge clock) begin
      if (hold_asks != hold_seen) begin
         hold_seen = hold_asks;
         hold_left = 400;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_pct);
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("FAIL");
         $finish;
      end
   end

   function automatic logic signed [23:0] clamp24(longint v);
      if (v > 8388607) return 24'sd8388607;
      if (v < -8388608) return -24'sd8388608;
      return v[23:0];
   endfunction

   // one item on the request channel, with random idle cycles in front
   task automatic send_item(logic op, logic signed [31:0] c, logic signed [31:0] a,
                            logic signed [31:0] b, logic first, logic last,
                            logic signed [23:0] cx, logic signed [23:0] cy,
                            logic signed [23:0] cz);
      while ($urandom_range(99) < send_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_opcode <= op;
      req_center_height <= c;
      req_neighbor_a_height <= a;
      req_neighbor_b_height <= b;
      req_first <= first;
      req_last <= last;
      req_cam_x <= cx;
      req_cam_y <= cy;
      req_cam_z <= cz;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      items_sent++;
   endtask

   task automatic sample(logic signed [31:0] c, logic signed [31:0] a,
                         logic signed [31:0] b, logic first, logic last);
      send_item(OpSample, c, a, b, first, last,
                24'($urandom), 24'($urandom), 24'($urandom));
   endtask

   task automatic query(longint dx, longint dy, longint dz);
      send_item(OpQuery, $urandom, $urandom, $urandom, 1'($urandom), 1'($urandom),
                clamp24(ctr_x + dx), clamp24(ctr_y + dy), clamp24(ctr_z + dz));
   endtask

   // registers change only once every result is home and the block has drained
   task automatic configure(int cx, int cy, int cz, int q, int nl);
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (40) @(negedge clock);
      ctr_x = cx; ctr_y = cy; ctr_z = cz;
      csr_we <= 1'b1; csr_index <= CsrCenterX;   csr_wdata <= cx[23:0]; @(negedge clock);
      csr_index <= CsrCenterY;   csr_wdata <= cy[23:0]; @(negedge clock);
      csr_index <= CsrCenterZ;   csr_wdata <= cz[23:0]; @(negedge clock);
      csr_index <= CsrQuality;   csr_wdata <= q[23:0];  @(negedge clock);
      csr_index <= CsrNumLevels; csr_wdata <= nl[23:0]; @(negedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic longint cam_offset();
      int s;
      s = $urandom_range(12);
      return longint'($urandom_range(2 << s)) - longint'(1 << s);
   endfunction

   function automatic logic signed [31:0] height_base();
      case ($urandom_range(4))
         0: return 32'sd0;
         1: return $urandom_range(2) - 1;
         2: return $urandom;
         default: return int'($urandom_range(400000)) - 200000;
      endcase
   endfunction

   initial begin
      int cfg_x[6]  = '{0, 8388607, -8388608, 1000, -300, 0};
      int cfg_y[6]  = '{0, -8388608, 8388607, -2000, 77, 0};
      int cfg_z[6]  = '{0, 100, -5, 300, 0, 12345};
      int cfg_q[6]  = '{256, 65535, 0, 128, 512, 300};
      int cfg_nl[6] = '{8, 1, 0, 15, 4, 2};
      int n, len, pick;
      logic signed [31:0] c;

      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: field extremes, flags, clamp and both operations
      sample(32'sd0, 32'sd0, 32'sd0, 1'b1, 1'b1);                       // no error, no flags
      query(0, 0, 0);                                                   // zero divisor
      sample(32'sd7, 32'sd2, 32'sd3, 1'b1, 1'b1);                       // odd error truncated
      sample(32'sh7fffffff, 32'sh80000000, 32'sh80000000, 1'b1, 1'b0);  // clamp, above
      sample(-32'sd1, -32'sd1, -32'sd1, 1'b0, 1'b1);                    // below too
      query(0, 0, 0);
      query(8388607, 8388607, 8388607);                                 // top level
      query(-8388608, -8388608, -8388608);                              // blend kept
      sample(32'sd5000, 32'sd0, 32'sd0, 1'b1, 1'b0);
      sample(32'sd100, 32'sd100, 32'sd100, 1'b0, 1'b0);                 // no result
      sample(32'sd0, 32'sd0, 32'sd2000, 1'b0, 1'b1);
      for (int i = 0; i < 6; i++) query(40 << i, 0, 30 << i);
      send_item(OpQuery, 32'sd0, 32'sd0, 32'sd0, 1'b1, 1'b1,
                24'sd8388607, -24'sd8388608, 24'sd0);                   // flags ignored
      sample(-32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 1'b1, 1'b1);

      for (int ph = 0; ph < 6; ph++) begin
         configure(cfg_x[ph], cfg_y[ph], cfg_z[ph], cfg_q[ph], cfg_nl[ph]);
         // idling: sender 21 receiver 47, then swapped, then none
         send_pct = (ph < 2) ? 21 : (ph < 4) ? 47 : 0;
         recv_pct = (ph < 2) ? 47 : (ph < 4) ? 21 : 0;
         if (ph == 5) hold_asks++;   // long hold so the block backs up its input
         n = 0;
         while (n < 140) begin
            pick = $urandom_range(99);
            if (pick < 60) begin
               // well-formed block of samples
               len = $urandom_range(1, 6);
               for (int k = 0; k < len; k++) begin
                  c = height_base();
                  sample(c, c + int'($urandom_range(30000)) - 15000,
                         c + int'($urandom_range(30000)) - 15000,
                         k == 0, k == len - 1);
               end
               n += len;
            end else if (pick < 93) begin
               query(cam_offset(), cam_offset(), cam_offset());
               n++;
            end else begin
               // noise on every bit, broken blocks included
               send_item(1'($urandom), $urandom, $urandom, $urandom,
                         1'($urandom), 1'($urandom),
                         24'($urandom), 24'($urandom), 24'($urandom));
               n++;
            end
         end
      end

      req_valid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (40) @(negedge clock);
      if (fail_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
